// ===== rtl/core/qsm_pkg.sv =====
// Package for the QAM symbol mapper: mode codes, constellation constants
// and the job records that pass from the front end to the back end.
// No dependencies.
package qsm_pkg;

   // Configuration port geometry: one register at byte address 0.
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic [0:0] RegMode = 1'b0;

   // Depth of the job queue between front end and back end.
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Symbols per job and width of one raw symbol.
   localparam int SymsPerJob = 4;
   localparam int SymWidth   = 6;

   typedef enum logic [1:0] {
      ModeQpsk  = 2'd0,
      ModeQam16 = 2'd1,
      ModeQam64 = 2'd2
   } mode_type;

   // One classified request: the raw symbols in emit order and the index
   // of the last valid one.
   typedef struct packed {
      mode_type                                kind;
      logic [1:0]                              last_idx;
      logic [SymsPerJob-1:0][SymWidth-1:0]     syms;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

// ===== rtl/core/qsm_req_if.sv =====
// Request channel of the QAM symbol mapper: one data byte per request.
// Depends on nothing.
interface qsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_end;

   modport source (output valid, output data_byte, output block_end, input ready);
   modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

// ===== rtl/core/qsm_rsp_if.sv =====
// Result channel of the QAM symbol mapper: one constellation point per item.
// Depends on nothing.
interface qsm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] i_value;
   logic signed [15:0] q_value;
   logic               run_last;

   modport source (output valid, output i_value, output q_value, output run_last,
                   input ready);
   modport sink   (input valid, input i_value, input q_value, input run_last,
                   output ready);
endinterface

// ===== rtl/core/qam_symbol_mapper.sv =====
// Top level of the QAM symbol mapper: mode register on the APB-style port,
// front end, job queue and back end. Uses qsm_pkg, qsm_req_if, qsm_rsp_if.
//
//   Channel   Direction  Carries
//   req_chan  in         data_byte[7:0], block_end
//   rsp_chan  out        i_value[15:0], q_value[15:0] (Q4.12), run_last
//   csr_*     in/out     mode register at byte address 0
//
// The result register emits one point per cycle while rsp_chan.ready is high,
// and a request yields four points in QPSK, two in 16-QAM and one or two in
// 64-QAM, as the back end's symbol walk sets. The front end takes a request in
// the cycle it arrives while the two-entry job queue has room, so a stalled
// result channel backs up into the queue before req_chan.ready drops.
// Reset is synchronous and clears the mode, the packing state and the queue.
module qam_symbol_mapper
   import qsm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   qsm_req_if.sink                 req_chan,
   qsm_rsp_if.source               rsp_chan,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic [1:0] mode_ff, mode_in;
   logic       csr_write;
   logic       mode_hit;
   push_type   push;
   head_type   head;
   logic       queue_full;
   logic       pop;

   // Configuration port: mode register only.
   assign csr_pready = 1'b1;
   assign mode_hit   = (csr_paddr[2:2] == RegMode);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && mode_hit;
   assign mode_in    = csr_write ? csr_pwdata[1:0] : mode_ff;
   assign csr_prdata = mode_hit ? {{(CsrDataWidth - 2){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeQpsk;
      end else begin
         mode_ff <= mode_in;
      end
   end

   qsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .clear      (csr_write),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   qsm_job_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   qsm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // A job is never offered to a full queue.
   assert property (@(posedge clock) disable iff (reset) push.valid |-> !queue_full)
      else $error("job pushed into full queue");

   // The back end only retires a job that is present.
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("pop from empty queue");

   // The queue comes out of reset empty.
   assert property (@(posedge clock) reset |=> !head.valid)
      else $error("queue not empty after reset");

endmodule

// ===== rtl/core/qsm_front.sv =====
// Front end of the QAM symbol mapper: accepts requests, splits each byte
// into raw symbols and keeps the 64-QAM packing state. Uses qsm_pkg.
module qsm_front
   import qsm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     mode,
   input  logic           clear,
   qsm_req_if.sink        req_chan,
   input  logic           queue_full,
   output push_type       push
);

   localparam logic [1:0] PhaseFirst  = 2'd0;
   localparam logic [1:0] PhaseSecond = 2'd1;
   localparam logic [1:0] PhaseThird  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       accept;
   logic [7:0] b;
   logic       blk_end;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;
   assign blk_end        = req_chan.block_end;

   // Classify the byte and work out the next packing state.
   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      push      = '0;
      case (mode)
         ModeQpsk: begin
            push.valid        = accept;
            push.job.kind     = ModeQpsk;
            push.job.last_idx = 2'd3;
            push.job.syms[0]  = {4'b0, b[7:6]};
            push.job.syms[1]  = {4'b0, b[5:4]};
            push.job.syms[2]  = {4'b0, b[3:2]};
            push.job.syms[3]  = {4'b0, b[1:0]};
            if (accept && blk_end) begin
               phase_in = PhaseFirst;
               left_in  = 4'b0;
            end
         end
         ModeQam16: begin
            push.valid        = accept;
            push.job.kind     = ModeQam16;
            push.job.last_idx = 2'd1;
            push.job.syms[0]  = {2'b0, b[7:4]};
            push.job.syms[1]  = {2'b0, b[3:0]};
            if (accept && blk_end) begin
               phase_in = PhaseFirst;
               left_in  = 4'b0;
            end
         end
         ModeQam64: begin
            push.valid    = accept;
            push.job.kind = ModeQam64;
            case (phase_ff)
               PhaseSecond: begin
                  push.job.syms[0]  = {left_ff[1:0], b[7:4]};
                  push.job.syms[1]  = {b[3:0], 2'b0};
                  push.job.last_idx = blk_end ? 2'd1 : 2'd0;
                  if (accept) begin
                     phase_in = PhaseThird;
                     left_in  = b[3:0];
                  end
               end
               PhaseThird: begin
                  push.job.syms[0]  = {left_ff, b[7:6]};
                  push.job.syms[1]  = b[5:0];
                  push.job.last_idx = 2'd1;
                  if (accept) begin
                     phase_in = PhaseFirst;
                     left_in  = 4'b0;
                  end
               end
               default: begin
                  // Phase one, and the phase code that never arises.
                  push.job.syms[0]  = b[7:2];
                  push.job.syms[1]  = {b[1:0], 4'b0};
                  push.job.last_idx = blk_end ? 2'd1 : 2'd0;
                  if (accept) begin
                     phase_in = PhaseSecond;
                     left_in  = {2'b0, b[1:0]};
                  end
               end
            endcase
            if (accept && blk_end) begin
               phase_in = PhaseFirst;
               left_in  = 4'b0;
            end
         end
         default: begin
            // Unsupported mode: the request is taken and dropped.
         end
      endcase
      if (clear) begin
         phase_in = PhaseFirst;
         left_in  = 4'b0;
      end
   end

   // Packing state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseFirst;
         left_ff  <= 4'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== rtl/core/qsm_job_queue.sv =====
// Short job queue between the front end and the back end of the QAM
// symbol mapper. Uses qsm_pkg.
module qsm_job_queue
   import qsm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   job_type                  entries [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full       = (count_ff == QueueCntWidth'(QueueDepth));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.job   = entries[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// ===== rtl/core/qsm_back.sv =====
// Back end of the QAM symbol mapper: walks the symbols of the head job,
// maps each to an (I, Q) point and holds it in the output register.
// Uses qsm_pkg.
module qsm_back
   import qsm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  head_type  head,
   output logic      pop,
   qsm_rsp_if.source rsp_chan
);

   localparam logic signed [15:0] QpskMag    = 16'sd2896;
   localparam logic signed [15:0] Qam16Inner = 16'sd4096;
   localparam logic signed [15:0] Qam16Outer = 16'sd12288;
   localparam logic signed [15:0] Qam64Amp1  = 16'sd632;
   localparam logic signed [15:0] Qam64Amp3  = 16'sd1896;
   localparam logic signed [15:0] Qam64Amp5  = 16'sd3160;
   localparam logic signed [15:0] Qam64Amp7  = 16'sd4424;

   logic [1:0]         sym_idx_ff, sym_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_i_ff, rsp_i_in;
   logic signed [15:0] rsp_q_ff, rsp_q_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;
   logic               load;
   logic               is_last;
   logic [5:0]         sym;
   logic signed [15:0] map_i;
   logic signed [15:0] map_q;

   function automatic logic signed [15:0] qpsk_level(input logic neg);
      return neg ? -QpskMag : QpskMag;
   endfunction

   function automatic logic signed [15:0] qam16_level(input logic [1:0] y);
      logic signed [15:0] lvl;
      case (y)
         2'd0:    lvl = -Qam16Outer;
         2'd1:    lvl = -Qam16Inner;
         2'd2:    lvl = Qam16Inner;
         default: lvl = Qam16Outer;
      endcase
      return lvl;
   endfunction

   function automatic logic signed [15:0] qam64_level(input logic neg,
                                                      input logic [1:0] sel);
      logic signed [15:0] amp;
      case (sel)
         2'd0:    amp = Qam64Amp3;
         2'd1:    amp = Qam64Amp1;
         2'd2:    amp = Qam64Amp5;
         default: amp = Qam64Amp7;
      endcase
      return neg ? -amp : amp;
   endfunction

   assign sym      = head.job.syms[sym_idx_ff];
   assign is_last  = (sym_idx_ff == head.job.last_idx);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign load     = head.valid && out_free;
   assign pop      = load && is_last;

   // Constellation lookup for the current symbol.
   always_comb begin
      case (head.job.kind)
         ModeQpsk: begin
            map_i = qpsk_level(sym[1]);
            map_q = qpsk_level(sym[0]);
         end
         ModeQam16: begin
            map_i = qam16_level({sym[0] ^ sym[1], sym[0]});
            map_q = qam16_level({sym[2] ^ sym[3], sym[1] ^ sym[2]});
         end
         ModeQam64: begin
            map_i = qam64_level(sym[5], {sym[3], sym[1]});
            map_q = qam64_level(sym[4], {sym[2], sym[0]});
         end
         default: begin
            map_i = '0;
            map_q = '0;
         end
      endcase
   end

   // Symbol walk and output register.
   always_comb begin
      sym_idx_in   = sym_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_i_in     = rsp_i_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = head.valid;
      end
      if (load) begin
         rsp_i_in    = map_i;
         rsp_q_in    = map_q;
         rsp_last_in = is_last;
         sym_idx_in  = is_last ? 2'd0 : sym_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sym_idx_ff   <= sym_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_i_ff    <= rsp_i_in;
      rsp_q_ff    <= rsp_q_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.i_value  = rsp_i_ff;
   assign rsp_chan.q_value  = rsp_q_ff;
   assign rsp_chan.run_last = rsp_last_ff;

endmodule
